>>> sv/tsdg_pkg.sv
package tsdg_pkg;

  // Number of block dimensions, fixed by the descriptor format.
  localparam int unsigned BLOCK_DIMS      = 3;
  localparam int unsigned MAX_DESCRIPTORS = 64;
  // Counter width for descriptor rows and bursts, enough for the largest run.
  localparam int unsigned CNT_W           = 7;
  localparam logic [63:0] LIMIT62         = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] BURST_RESET     = 32'd256;
  localparam int unsigned ALU_STEPS       = 64;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_DIMS  = 3'd2,
    ST_BURST = 3'd3,
    ST_OVF   = 3'd4,
    ST_COUNT = 3'd5
  } status_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] res;
    logic [63:0] rem;
  } alu_rsp_t;

  // One job handed from the front end to the descriptor walker.
  typedef struct packed {
    logic             single;
    status_e          status;
    logic [CNT_W-1:0] rep;
    logic [CNT_W-1:0] ibc;
    logic [CNT_W-1:0] bc;
    logic [31:0]      burst;
    logic [31:0]      rem;
    logic [3:0]       eb;
    logic [63:0]      ext1;
    logic [63:0]      istr;
    logic [63:0]      ext2;
    logic [63:0]      ostr;
    logic [63:0]      start;
    logic [63:0]      rs;
  } job_t;

  typedef enum logic [4:0] {
    F_IDLE, F_CHECK, F_SL_EXT, F_SL_OFF, F_SL_STR, F_FU_STR, F_FU_EXT, F_POST,
    F_FIN, F_EXT, F_EXT_W, F_DIV, F_DIV_W, F_DIM0, F_DIV2, F_CNT, F_ISTR,
    F_OSTR, F_P1, F_OFFB, F_P2, F_DECIDE, F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROW,
    B_BURST
  } back_state_e;

  // True when a + b leaves the 62-bit range.
  function automatic logic add_ovf(logic [63:0] a, logic [63:0] b);
    add_ovf = (a > LIMIT62) || (b > (LIMIT62 - a));
  endfunction

endpackage

>>> sv/tensor_slice_dma_descriptor_gen_top.sv
// Strided DMA descriptor generator. Load the tensor one dimension per
// transfer, innermost first, with start_i while busy_o is low; the transfer
// with last_dim_i set closes the run and results follow, each shown for one
// cycle with strobe_o and the last one marked by last_result_o. The receiver
// cannot stall: every strobed result must be taken in that cycle. A loading
// transfer keeps busy_o high for three steps of the serial multiply/divide
// unit when the dimension is sliced and two when it is fused, and only
// through the check and post states on a bad range or a fourth sliced
// dimension; once an error is latched, later transfers are taken without
// going busy. The closing transfer adds up to ten more such steps before
// the job reaches the descriptor walker, which picks up each job and then
// emits one descriptor per cycle, with a row setup state per repeat row.
// Write burst_bytes with cfg_we_i only while no run is in progress.
module tensor_slice_dma_descriptor_gen_top import tsdg_pkg::*; #(
  parameter int unsigned MaxDesc = MAX_DESCRIPTORS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [30:0] dim_size_i,
  input  logic [31:0] slice_low_i,
  input  logic [30:0] slice_high_i,
  input  logic [3:0]  element_bytes_i,
  input  logic        last_dim_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        strobe_o,
  output logic [31:0] inner_length_o,
  output logic [61:0] inner_count_o,
  output logic [61:0] inner_stride_o,
  output logic [61:0] outer_count_o,
  output logic [61:0] outer_stride_o,
  output logic [61:0] base_offset_o,
  output logic [2:0]  status_o,
  output logic        last_result_o
);

  logic [31:0] burst_q;
  logic        push, full, avail, pop;
  job_t        job_in, job_out;

  // Burst size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= BURST_RESET;
    end else if (cfg_we_i) begin
      burst_q <= cfg_wdata_i;
    end
  end

  tsdg_front #(.MaxDesc(MaxDesc)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .dim_size_i      (dim_size_i),
    .slice_low_i     (slice_low_i),
    .slice_high_i    (slice_high_i),
    .element_bytes_i (element_bytes_i),
    .last_dim_i      (last_dim_i),
    .burst_bytes_i   (burst_q),
    .full_i          (full),
    .busy_o          (busy_o),
    .push_o          (push),
    .job_o           (job_in)
  );

  tsdg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .job_o   (job_out)
  );

  tsdg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .job_i          (job_out),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .inner_length_o (inner_length_o),
    .inner_count_o  (inner_count_o),
    .inner_stride_o (inner_stride_o),
    .outer_count_o  (outer_count_o),
    .outer_stride_o (outer_stride_o),
    .base_offset_o  (base_offset_o),
    .status_o       (status_o),
    .last_result_o  (last_result_o)
  );

endmodule

>>> sv/tsdg_alu.sv
module tsdg_alu import tsdg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [5:0]    cnt_q, cnt_d;
  alu_op_e       op_q, op_d;
  logic [63:0]   a_q, a_d;
  logic [63:0]   x_q, x_d;
  logic [64:0]   acc_q, acc_d;
  logic          ovf_q, ovf_d;
  logic [64:0]   shifted;

  // One bit per cycle: shift-add multiply with a sticky range check, or
  // restoring divide.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    op_d    = op_q;
    a_d     = a_q;
    x_d     = x_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    shifted = {acc_q[63:0], x_q[63]};
    if (busy_q) begin
      if (op_q == ALU_MUL) begin
        acc_d = {acc_q[63:0], 1'b0} + (x_q[63] ? {1'b0, a_q} : 65'd0);
        ovf_d = ovf_q | (acc_d > {1'b0, LIMIT62});
        x_d   = {x_q[62:0], 1'b0};
      end else begin
        if (shifted >= {1'b0, a_q}) begin
          acc_d = shifted - {1'b0, a_q};
          x_d   = {x_q[62:0], 1'b1};
        end else begin
          acc_d = shifted;
          x_d   = {x_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(ALU_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      acc_d  = '0;
      if (req_i.op == ALU_MUL) begin
        a_d   = req_i.a;
        x_d   = req_i.b;
        ovf_d = (req_i.a > LIMIT62) || (req_i.b > LIMIT62);
      end else begin
        a_d   = req_i.b;
        x_d   = req_i.a;
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    op_q  <= op_d;
    a_q   <= a_d;
    x_q   <= x_d;
    acc_q <= acc_d;
    ovf_q <= ovf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.res  = (op_q == ALU_MUL) ? acc_q[63:0] : x_q;
  assign rsp_o.rem  = acc_q[63:0];

endmodule

>>> sv/tsdg_front.sv
module tsdg_front import tsdg_pkg::*; #(
  parameter int unsigned MaxDesc = MAX_DESCRIPTORS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dim_size_i,
  input  logic [31:0] slice_low_i,
  input  logic [30:0] slice_high_i,
  input  logic [3:0]  element_bytes_i,
  input  logic        last_dim_i,
  input  logic [31:0] burst_bytes_i,
  input  logic        full_i,
  output logic        busy_o,
  output logic        push_o,
  output job_t        job_o
);

  localparam logic [63:0]         MaxLim  = 64'(MaxDesc);
  localparam logic [2*CNT_W-1:0]  MaxProd = (2*CNT_W)'(MaxDesc);

  front_state_e state_q, state_d;
  logic [30:0]  dim_q, dim_d;
  logic [31:0]  low_q, low_d;
  logic [30:0]  high_q, high_d;
  logic [3:0]   eb_q, eb_d;
  logic         last_q, last_d;
  logic [1:0]   cnt_q, cnt_d;
  logic [1:0]   idx_q, idx_d;
  logic [63:0]  fused_q, fused_d;
  logic [63:0]  rstride_q, rstride_d;
  logic [63:0]  prior_q, prior_d;
  logic [63:0]  start_q, start_d;
  logic [63:0]  ext_q [BLOCK_DIMS];
  logic [63:0]  ext_d [BLOCK_DIMS];
  logic [63:0]  str_q [BLOCK_DIMS];
  logic [63:0]  str_d [BLOCK_DIMS];
  status_e      err_q, err_d;
  logic         ovf_q, ovf_d;
  logic [63:0]  rs_q, rs_d;
  logic [63:0]  t_q, t_d;
  logic [63:0]  bc_q, bc_d;
  logic [31:0]  rem_q, rem_d;
  logic [63:0]  ibc_q, ibc_d;
  logic [63:0]  istr_q, istr_d;
  logic [63:0]  ostr_q, ostr_d;
  job_t         job_q, job_d;
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [30:0]  len;
  logic [63:0]  sum;
  logic [2*CNT_W-1:0] prod;
  logic         too_many;

  tsdg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign len      = high_q - low_q[30:0];
  assign sum      = start_q + alu_rsp.res;
  assign prod     = ibc_q[CNT_W-1:0] * fused_q[CNT_W-1:0];
  assign too_many = (ibc_q != 64'd0) &&
                    ((ibc_q > MaxLim) || (fused_q > MaxLim) || (prod > MaxProd));

  // Item loading, then the finishing sequence, all on the shared serial unit.
  always_comb begin
    state_d   = state_q;
    dim_d     = dim_q;
    low_d     = low_q;
    high_d    = high_q;
    eb_d      = eb_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    fused_d   = fused_q;
    rstride_d = rstride_q;
    prior_d   = prior_q;
    start_d   = start_q;
    ext_d     = ext_q;
    str_d     = str_q;
    err_d     = err_q;
    ovf_d     = ovf_q;
    rs_d      = rs_q;
    t_d       = t_q;
    bc_d      = bc_q;
    rem_d     = rem_q;
    ibc_d     = ibc_q;
    istr_d    = istr_q;
    ostr_d    = ostr_q;
    job_d     = job_q;
    push_o    = 1'b0;
    alu_req   = '{start: 1'b0, op: ALU_MUL, a: 64'd0, b: 64'd0};

    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          dim_d  = dim_size_i;
          low_d  = slice_low_i;
          high_d = slice_high_i;
          eb_d   = element_bytes_i;
          last_d = last_dim_i;
          ovf_d  = 1'b0;
          if (err_q != ST_OK) begin
            state_d = last_dim_i ? F_FIN : F_IDLE;
          end else begin
            state_d = F_CHECK;
          end
        end
      end
      F_CHECK: begin
        if (low_q[31] || ({1'b0, high_q} <= low_q)) begin
          err_d   = ST_RANGE;
          state_d = F_POST;
        end else if (len != dim_q) begin
          if (cnt_q == 2'(BLOCK_DIMS)) begin
            err_d   = ST_DIMS;
            state_d = F_POST;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_MUL, a: 64'(len), b: fused_q};
            state_d = F_SL_EXT;
          end
        end else begin
          alu_req = '{start: 1'b1, op: ALU_MUL, a: rstride_q, b: 64'(dim_q)};
          state_d = F_FU_STR;
        end
      end
      F_SL_EXT: begin
        if (alu_rsp.done) begin
          ext_d[cnt_q] = alu_rsp.res;
          ovf_d        = ovf_q | alu_rsp.ovf;
          fused_d      = 64'd1;
          alu_req      = '{start: 1'b1, op: ALU_MUL, a: 64'(low_q), b: rstride_q};
          state_d      = F_SL_OFF;
        end
      end
      F_SL_OFF: begin
        if (alu_rsp.done) begin
          ovf_d   = ovf_q | alu_rsp.ovf | add_ovf(start_q, alu_rsp.res);
          start_d = sum;
          alu_req = '{start: 1'b1, op: ALU_MUL, a: rstride_q, b: 64'(dim_q)};
          state_d = F_SL_STR;
        end
      end
      F_SL_STR: begin
        if (alu_rsp.done) begin
          str_d[cnt_q] = prior_q;
          cnt_d        = cnt_q + 2'd1;
          rstride_d    = alu_rsp.res;
          prior_d      = alu_rsp.res;
          ovf_d        = ovf_q | alu_rsp.ovf;
          state_d      = F_POST;
        end
      end
      F_FU_STR: begin
        if (alu_rsp.done) begin
          rstride_d = alu_rsp.res;
          ovf_d     = ovf_q | alu_rsp.ovf;
          alu_req   = '{start: 1'b1, op: ALU_MUL, a: fused_q, b: 64'(dim_q)};
          state_d   = F_FU_EXT;
        end
      end
      F_FU_EXT: begin
        if (alu_rsp.done) begin
          fused_d = alu_rsp.res;
          ovf_d   = ovf_q | alu_rsp.ovf;
          state_d = F_POST;
        end
      end
      F_POST: begin
        if (ovf_q) begin
          err_d = ST_OVF;
        end
        state_d = last_q ? F_FIN : F_IDLE;
      end
      F_FIN: begin
        if (err_q != ST_OK) begin
          job_d        = '0;
          job_d.single = 1'b1;
          job_d.status = err_q;
          state_d      = F_PUSH;
        end else begin
          idx_d   = 2'd0;
          ovf_d   = 1'b0;
          state_d = F_EXT;
        end
      end
      // Fill the unused block dimensions from the fused remainder.
      F_EXT: begin
        if (idx_q >= cnt_q) begin
          ext_d[idx_q] = fused_q;
          str_d[idx_q] = prior_q;
          fused_d      = 64'd1;
          if (idx_q != 2'(BLOCK_DIMS - 1)) begin
            alu_req = '{start: 1'b1, op: ALU_MUL, a: fused_q, b: prior_q};
            state_d = F_EXT_W;
          end else begin
            state_d = F_DIV;
          end
        end else if (idx_q == 2'(BLOCK_DIMS - 1)) begin
          state_d = F_DIV;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      F_EXT_W: begin
        if (alu_rsp.done) begin
          prior_d = alu_rsp.res;
          ovf_d   = ovf_q | alu_rsp.ovf;
          idx_d   = idx_q + 2'd1;
          state_d = F_EXT;
        end
      end
      F_DIV: begin
        if (ovf_q) begin
          job_d        = '0;
          job_d.single = 1'b1;
          job_d.status = ST_OVF;
          state_d      = F_PUSH;
        end else begin
          if (fused_q != 64'd0) begin
            alu_req = '{start: 1'b1, op: ALU_DIV, a: rstride_q, b: fused_q};
          end
          state_d = F_DIV_W;
        end
      end
      F_DIV_W: begin
        if ((fused_q == 64'd0) || alu_rsp.done) begin
          rs_d = (fused_q == 64'd0) ? 64'd0 : alu_rsp.res;
          if (burst_bytes_i == 32'd0) begin
            job_d        = '0;
            job_d.single = 1'b1;
            job_d.status = ST_BURST;
            state_d      = F_PUSH;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_MUL, a: ext_q[0], b: 64'(eb_q)};
            state_d = F_DIM0;
          end
        end
      end
      F_DIM0: begin
        if (alu_rsp.done) begin
          if (alu_rsp.ovf) begin
            job_d        = '0;
            job_d.single = 1'b1;
            job_d.status = ST_OVF;
            state_d      = F_PUSH;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_DIV, a: alu_rsp.res,
                        b: 64'(burst_bytes_i)};
            state_d = F_DIV2;
          end
        end
      end
      F_DIV2: begin
        if (alu_rsp.done) begin
          bc_d    = alu_rsp.res;
          rem_d   = alu_rsp.rem[31:0];
          ibc_d   = alu_rsp.res + 64'(alu_rsp.rem != 64'd0);
          state_d = F_CNT;
        end
      end
      F_CNT: begin
        if (too_many) begin
          job_d        = '0;
          job_d.single = 1'b1;
          job_d.status = ST_COUNT;
          state_d      = F_PUSH;
        end else begin
          alu_req = '{start: 1'b1, op: ALU_MUL, a: str_q[1], b: 64'(eb_q)};
          state_d = F_ISTR;
        end
      end
      F_ISTR: begin
        if (alu_rsp.done) begin
          istr_d  = alu_rsp.res;
          ovf_d   = ovf_q | alu_rsp.ovf;
          alu_req = '{start: 1'b1, op: ALU_MUL, a: str_q[2], b: 64'(eb_q)};
          state_d = F_OSTR;
        end
      end
      F_OSTR: begin
        if (alu_rsp.done) begin
          ostr_d = alu_rsp.res;
          ovf_d  = ovf_q | alu_rsp.ovf;
          if (ovf_q || alu_rsp.ovf) begin
            job_d        = '0;
            job_d.single = 1'b1;
            job_d.status = ST_OVF;
            state_d      = F_PUSH;
          end else if (fused_q == 64'd0) begin
            state_d = F_DECIDE;
          end else begin
            // The walk's largest offsets decide whether any of them overflows.
            alu_req = '{start: 1'b1, op: ALU_MUL, a: rs_q, b: fused_q - 64'd1};
            state_d = F_P1;
          end
        end
      end
      F_P1: begin
        if (alu_rsp.done) begin
          ovf_d   = ovf_q | alu_rsp.ovf | add_ovf(start_q, alu_rsp.res);
          alu_req = '{start: 1'b1, op: ALU_MUL, a: sum, b: 64'(eb_q)};
          state_d = F_OFFB;
        end
      end
      F_OFFB: begin
        if (alu_rsp.done) begin
          ovf_d = ovf_q | alu_rsp.ovf;
          t_d   = alu_rsp.res;
          if (ibc_q != 64'd0) begin
            alu_req = '{start: 1'b1, op: ALU_MUL, a: ibc_q - 64'd1,
                        b: 64'(burst_bytes_i)};
            state_d = F_P2;
          end else begin
            state_d = F_DECIDE;
          end
        end
      end
      F_P2: begin
        if (alu_rsp.done) begin
          ovf_d   = ovf_q | alu_rsp.ovf | add_ovf(t_q, alu_rsp.res);
          state_d = F_DECIDE;
        end
      end
      F_DECIDE: begin
        job_d = '0;
        if (ovf_q) begin
          job_d.single = 1'b1;
          job_d.status = ST_OVF;
        end else if ((ibc_q == 64'd0) || (fused_q == 64'd0)) begin
          job_d.single = 1'b1;
          job_d.status = ST_OK;
        end else begin
          job_d.status = ST_OK;
          job_d.rep    = fused_q[CNT_W-1:0];
          job_d.ibc    = ibc_q[CNT_W-1:0];
          job_d.bc     = bc_q[CNT_W-1:0];
          job_d.burst  = burst_bytes_i;
          job_d.rem    = rem_q;
          job_d.eb     = eb_q;
          job_d.ext1   = ext_q[1];
          job_d.istr   = istr_q;
          job_d.ext2   = ext_q[2];
          job_d.ostr   = ostr_q;
          job_d.start  = start_q;
          job_d.rs     = rs_q;
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o    = 1'b1;
          cnt_d     = 2'd0;
          fused_d   = 64'd1;
          rstride_d = 64'd1;
          prior_d   = 64'd1;
          start_d   = 64'd0;
          err_d     = ST_OK;
          for (int i = 0; i < BLOCK_DIMS; i++) begin
            ext_d[i] = 64'd0;
            str_d[i] = 64'd0;
          end
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      cnt_q     <= 2'd0;
      fused_q   <= 64'd1;
      rstride_q <= 64'd1;
      prior_q   <= 64'd1;
      start_q   <= 64'd0;
      err_q     <= ST_OK;
      for (int i = 0; i < BLOCK_DIMS; i++) begin
        ext_q[i] <= 64'd0;
        str_q[i] <= 64'd0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fused_q   <= fused_d;
      rstride_q <= rstride_d;
      prior_q   <= prior_d;
      start_q   <= start_d;
      err_q     <= err_d;
      ext_q     <= ext_d;
      str_q     <= str_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dim_q  <= dim_d;
    low_q  <= low_d;
    high_q <= high_d;
    eb_q   <= eb_d;
    last_q <= last_d;
    idx_q  <= idx_d;
    ovf_q  <= ovf_d;
    rs_q   <= rs_d;
    t_q    <= t_d;
    bc_q   <= bc_d;
    rem_q  <= rem_d;
    ibc_q  <= ibc_d;
    istr_q <= istr_d;
    ostr_q <= ostr_d;
    job_q  <= job_d;
  end

  assign busy_o = (state_q != F_IDLE);
  assign job_o  = job_q;

endmodule

>>> sv/tsdg_queue.sv
module tsdg_queue import tsdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic avail_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  // Two-entry queue between the front end and the walker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

endmodule

>>> sv/tsdg_back.sv
module tsdg_back import tsdg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  job_t        job_i,
  output logic        pop_o,
  output logic        strobe_o,
  output logic [31:0] inner_length_o,
  output logic [61:0] inner_count_o,
  output logic [61:0] inner_stride_o,
  output logic [61:0] outer_count_o,
  output logic [61:0] outer_stride_o,
  output logic [61:0] base_offset_o,
  output logic [2:0]  status_o,
  output logic        last_result_o
);

  back_state_e      state_q, state_d;
  job_t             cur_q, cur_d;
  logic [CNT_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [63:0]      off_q, off_d;
  logic [63:0]      offb_q, offb_d;
  logic [63:0]      jacc_q, jacc_d;
  logic             strobe_q, strobe_d;
  logic [31:0]      len_q, len_d;
  logic [61:0]      icnt_q, icnt_d;
  logic [61:0]      istr_q, istr_d;
  logic [61:0]      ocnt_q, ocnt_d;
  logic [61:0]      ostr_q, ostr_d;
  logic [61:0]      base_q, base_d;
  status_e          status_q, status_d;
  logic             last_q, last_d;
  logic             row_end, run_end;
  logic [63:0]      base;

  assign row_end = (j_q == cur_q.ibc - CNT_W'(1));
  assign run_end = (r_q == cur_q.rep - CNT_W'(1));
  assign base    = offb_q + jacc_q;

  // Walk rows and bursts, one descriptor per cycle within a row.
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    r_d      = r_q;
    j_d      = j_q;
    off_d    = off_q;
    offb_d   = offb_q;
    jacc_d   = jacc_q;
    strobe_d = 1'b0;
    len_d    = len_q;
    icnt_d   = icnt_q;
    istr_d   = istr_q;
    ocnt_d   = ocnt_q;
    ostr_d   = ostr_q;
    base_d   = base_q;
    status_d = status_q;
    last_d   = last_q;
    pop_o    = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          cur_d = job_i;
          if (job_i.single) begin
            strobe_d = 1'b1;
            len_d    = '0;
            icnt_d   = '0;
            istr_d   = '0;
            ocnt_d   = '0;
            ostr_d   = '0;
            base_d   = '0;
            status_d = job_i.status;
            last_d   = 1'b1;
          end else begin
            r_d     = '0;
            off_d   = job_i.start;
            state_d = B_ROW;
          end
        end
      end
      B_ROW: begin
        offb_d  = 64'(off_q * cur_q.eb);
        j_d     = '0;
        jacc_d  = '0;
        state_d = B_BURST;
      end
      B_BURST: begin
        strobe_d = 1'b1;
        len_d    = (j_q < cur_q.bc) ? cur_q.burst : cur_q.rem;
        icnt_d   = cur_q.ext1[61:0];
        istr_d   = cur_q.istr[61:0];
        ocnt_d   = cur_q.ext2[61:0];
        ostr_d   = cur_q.ostr[61:0];
        base_d   = base[61:0];
        status_d = ST_OK;
        last_d   = row_end && run_end;
        j_d      = j_q + CNT_W'(1);
        jacc_d   = jacc_q + 64'(cur_q.burst);
        if (row_end) begin
          if (run_end) begin
            state_d = B_IDLE;
          end else begin
            r_d     = r_q + CNT_W'(1);
            off_d   = off_q + cur_q.rs;
            state_d = B_ROW;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    r_q      <= r_d;
    j_q      <= j_d;
    off_q    <= off_d;
    offb_q   <= offb_d;
    jacc_q   <= jacc_d;
    len_q    <= len_d;
    icnt_q   <= icnt_d;
    istr_q   <= istr_d;
    ocnt_q   <= ocnt_d;
    ostr_q   <= ostr_d;
    base_q   <= base_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign inner_length_o = len_q;
  assign inner_count_o  = icnt_q;
  assign inner_stride_o = istr_q;
  assign outer_count_o  = ocnt_q;
  assign outer_stride_o = ostr_q;
  assign base_offset_o  = base_q;
  assign status_o       = status_q;
  assign last_result_o  = last_q;

endmodule

>>> bench/tb_tensor_slice_dma_descriptor_gen_top.sv
`timescale 1ns / 1ps

module tb_tensor_slice_dma_descriptor_gen_top;
  import tsdg_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [31:0] inner_length;
    logic [61:0] inner_count;
    logic [61:0] inner_stride;
    logic [61:0] outer_count;
    logic [61:0] outer_stride;
    logic [61:0] base_offset;
    status_e     status;
    logic        last_result;
  } descriptor_t;

  typedef struct {
    logic [30:0] dim;
    logic [31:0] low;
    logic [30:0] high;
    logic [3:0]  eb;
    logic        last;
    logic        typed;
    status_e     status;
  } load_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [30:0] dim_size_i = '0;
  logic [31:0] slice_low_i = '0;
  logic [30:0] slice_high_i = '0;
  logic [3:0]  element_bytes_i = '0;
  logic        last_dim_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        strobe_o;
  logic [31:0] inner_length_o;
  logic [61:0] inner_count_o;
  logic [61:0] inner_stride_o;
  logic [61:0] outer_count_o;
  logic [61:0] outer_stride_o;
  logic [61:0] base_offset_o;
  logic [2:0]  status_o;
  logic        last_result_o;

  tensor_slice_dma_descriptor_gen_top i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .dim_size_i, .slice_low_i, .slice_high_i,
    .element_bytes_i, .last_dim_i, .cfg_we_i, .cfg_wdata_i, .strobe_o,
    .inner_length_o, .inner_count_o, .inner_stride_o, .outer_count_o,
    .outer_stride_o, .base_offset_o, .status_o, .last_result_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the tensor layout gathered so far and the burst register.
  logic [31:0] burst_bytes;
  int unsigned sliced_dims;
  logic [63:0] fused_extent, running_stride, prior_stride, start_offset;
  logic [63:0] block_extent [BLOCK_DIMS];
  logic [63:0] block_stride [BLOCK_DIMS];
  status_e     load_status;
  bit          wrapped;

  descriptor_t descriptor_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          no_gaps = 1'b0;

  function automatic logic [63:0] mul62(logic [63:0] a, logic [63:0] b);
    if (a > LIMIT62 || b > LIMIT62 || (a != 0 && b > LIMIT62 / a)) begin
      wrapped = 1'b1;
      return '0;
    end
    return a * b;
  endfunction

  function automatic logic [63:0] add62(logic [63:0] a, logic [63:0] b);
    if (a > LIMIT62 || b > LIMIT62 - a) begin
      wrapped = 1'b1;
      return '0;
    end
    return a + b;
  endfunction

  function automatic void clear_layout();
    sliced_dims = 0;
    fused_extent = 1;
    running_stride = 1;
    prior_stride = 1;
    start_offset = 0;
    for (int i = 0; i < BLOCK_DIMS; i++) begin
      block_extent[i] = 0;
      block_stride[i] = 0;
    end
    load_status = ST_OK;
  endfunction

  function automatic void push_single(status_e code);
    descriptor_t d;
    d.inner_length = '0;
    d.inner_count = '0;
    d.inner_stride = '0;
    d.outer_count = '0;
    d.outer_stride = '0;
    d.base_offset = '0;
    d.status = code;
    d.last_result = 1'b1;
    descriptor_q.insert(descriptor_q.size(), d);
  endfunction

  // Folds one dimension into the layout: sliced dims open a block dimension.
  function automatic void fold_dimension(logic [30:0] dim, logic [31:0] low, logic [30:0] high);
    logic [63:0] len;
    wrapped = 1'b0;
    if (low[31] || {33'd0, high} <= {32'd0, low}) begin
      load_status = ST_RANGE;
      return;
    end
    len = {33'd0, high} - {32'd0, low};
    if (len != {33'd0, dim}) begin
      if (sliced_dims >= BLOCK_DIMS) begin
        load_status = ST_DIMS;
        return;
      end
      block_extent[sliced_dims] = mul62(len, fused_extent);
      fused_extent = 1;
      start_offset = add62(start_offset, mul62({32'd0, low}, running_stride));
      block_stride[sliced_dims] = prior_stride;
      sliced_dims++;
      running_stride = mul62(running_stride, {33'd0, dim});
      prior_stride = running_stride;
    end else begin
      running_stride = mul62(running_stride, {33'd0, dim});
      fused_extent = mul62(fused_extent, {33'd0, dim});
    end
    if (wrapped) load_status = ST_OVF;
  endfunction

  // Closes the run and queues the burst-split descriptors it yields.
  function automatic void emit_descriptors(logic [3:0] eb_in);
    logic [63:0] ext [BLOCK_DIMS];
    logic [63:0] str [BLOCK_DIMS];
    logic [63:0] prior, fused, rep_count, rep_stride, eb, dim0, bc, rem, ibc;
    logic [63:0] istr, ostr, off, offb, r_first, boff;
    descriptor_t batch[$];
    descriptor_t d;
    if (load_status != ST_OK) begin
      push_single(load_status);
      return;
    end
    wrapped = 1'b0;
    eb = {60'd0, eb_in};
    prior = prior_stride;
    fused = fused_extent;
    for (int i = 0; i < BLOCK_DIMS; i++) begin
      ext[i] = block_extent[i];
      str[i] = block_stride[i];
      if (i >= sliced_dims) begin
        ext[i] = fused;
        str[i] = prior;
        if (i + 1 < BLOCK_DIMS) prior = mul62(ext[i], str[i]);
        fused = 1;
      end
    end
    if (wrapped) begin
      push_single(ST_OVF);
      return;
    end
    rep_count = fused;
    rep_stride = (fused != 0) ? running_stride / fused : 0;
    if (burst_bytes == 0) begin
      push_single(ST_BURST);
      return;
    end
    dim0 = mul62(ext[0], eb);
    if (wrapped) begin
      push_single(ST_OVF);
      return;
    end
    bc = dim0 / burst_bytes;
    rem = dim0 % burst_bytes;
    ibc = bc + ((rem != 0) ? 1 : 0);
    if (ibc != 0 && rep_count > MAX_DESCRIPTORS / ibc) begin
      push_single(ST_COUNT);
      return;
    end
    istr = mul62(str[1], eb);
    ostr = mul62(str[2], eb);
    if (wrapped) begin
      push_single(ST_OVF);
      return;
    end
    // With no bursts only the farthest row offset can overflow.
    r_first = (ibc == 0 && rep_count != 0) ? rep_count - 1 : 0;
    for (logic [63:0] r = r_first; r < rep_count; r++) begin
      off = add62(start_offset, mul62(rep_stride, r));
      offb = mul62(off, eb);
      for (logic [63:0] j = 0; j < ibc; j++) begin
        d.inner_length = (j < bc) ? burst_bytes : rem[31:0];
        d.inner_count = ext[1][61:0];
        d.inner_stride = istr[61:0];
        d.outer_count = ext[2][61:0];
        d.outer_stride = ostr[61:0];
        boff = add62(offb, mul62(j, {32'd0, burst_bytes}));
        d.base_offset = boff[61:0];
        d.status = ST_OK;
        d.last_result = 1'b0;
        batch.insert(batch.size(), d);
      end
    end
    if (wrapped) begin
      push_single(ST_OVF);
      return;
    end
    if (batch.size() == 0) begin
      push_single(ST_OK);
      return;
    end
    batch[batch.size() - 1].last_result = 1'b1;
    foreach (batch[k]) descriptor_q.insert(descriptor_q.size(), batch[k]);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result checking: every strobed descriptor against the oldest expectation.
  always @(posedge clk_i) begin
    descriptor_t e;
    if (strobe_o) begin
      if (descriptor_q.size() == 0) begin
        report_mismatch("unexpected descriptor, status", status_o, 0);
      end else begin
        e = descriptor_q.pop_front();
        if (inner_length_o !== e.inner_length)
          report_mismatch("inner_length", inner_length_o, e.inner_length);
        if (inner_count_o !== e.inner_count)
          report_mismatch("inner_count", inner_count_o, e.inner_count);
        if (inner_stride_o !== e.inner_stride)
          report_mismatch("inner_stride", inner_stride_o, e.inner_stride);
        if (outer_count_o !== e.outer_count)
          report_mismatch("outer_count", outer_count_o, e.outer_count);
        if (outer_stride_o !== e.outer_stride)
          report_mismatch("outer_stride", outer_stride_o, e.outer_stride);
        if (base_offset_o !== e.base_offset)
          report_mismatch("base_offset", base_offset_o, e.base_offset);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (last_result_o !== e.last_result)
          report_mismatch("last_result", last_result_o, e.last_result);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drives one dimension transfer and waits until the block takes it.
  task automatic load_dimension(load_row_t row);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    dim_size_i <= row.dim;
    slice_low_i <= row.low;
    slice_high_i <= row.high;
    element_bytes_i <= row.eb;
    last_dim_i <= row.last;
    do @(posedge clk_i); while (busy_o);
    if (load_status == ST_OK) fold_dimension(row.dim, row.low, row.high);
    if (row.last) begin
      if (row.typed) begin
        push_single(row.status);
      end else begin
        emit_descriptors(row.eb);
      end
      clear_layout();
    end
  endtask

  // Lowers start and waits until every queued descriptor has been seen.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (descriptor_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_burst(logic [31:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    burst_bytes = value;
  endtask

  // One random tensor of one to four dimensions, mostly well formed.
  task automatic random_tensor(inout int unsigned items);
    load_row_t row;
    int unsigned ndims, pick;
    ndims = $urandom_range(1, 4);
    for (int k = 0; k < ndims; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        row.dim = 31'($urandom);
        row.low = $urandom;
        row.high = 31'($urandom);
      end else if (pick < 10) begin
        row.dim = 31'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
        row.low = '0;
        row.high = row.dim;
      end else begin
        row.dim = 31'($urandom_range(1, 12));
        if ($urandom_range(0, 1)) begin
          row.low = '0;
          row.high = row.dim;
        end else begin
          row.low = $urandom_range(0, row.dim - 1);
          row.high = 31'($urandom_range(row.low + 1, row.dim + 1));
        end
      end
      row.eb = 4'(($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15));
      row.last = (k == ndims - 1);
      row.typed = 1'b0;
      row.status = ST_OK;
      load_dimension(row);
      items++;
    end
  endtask

  load_row_t directed [] = '{
    '{31'd4, 32'd0, 31'd4, 4'd4, 1'b1, 1'b0, ST_OK},
    '{31'd4, 32'h8000_0000, 31'd4, 4'd1, 1'b1, 1'b1, ST_RANGE},
    '{31'd5, 32'd3, 31'd3, 4'd1, 1'b1, 1'b1, ST_RANGE},
    '{31'd4, 32'd0, 31'd2, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd4, 32'd1, 31'd3, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd4, 32'd2, 31'd4, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd4, 32'd0, 31'd1, 4'd2, 1'b1, 1'b1, ST_DIMS},
    '{31'd6, 32'd5, 31'd2, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd6, 32'd0, 31'd6, 4'd1, 1'b1, 1'b1, ST_RANGE},
    '{31'h7FFF_FFFF, 32'd0, 31'h7FFF_FFFF, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'h7FFF_FFFF, 32'd0, 31'h7FFF_FFFF, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'h7FFF_FFFF, 32'd0, 31'h7FFF_FFFF, 4'd1, 1'b1, 1'b1, ST_OVF},
    '{31'd3000, 32'd0, 31'd3000, 4'd8, 1'b1, 1'b1, ST_COUNT},
    '{31'd4, 32'd0, 31'd6, 4'd2, 1'b1, 1'b0, ST_OK},
    '{31'd5, 32'd0, 31'd5, 4'd0, 1'b1, 1'b0, ST_OK},
    '{31'd2, 32'd0, 31'd2, 4'd15, 1'b1, 1'b0, ST_OK},
    '{31'h7FFF_FFFF, 32'h7FFF_FFFE, 31'h7FFF_FFFF, 4'd8, 1'b1, 1'b0, ST_OK},
    '{31'd8, 32'd2, 31'd5, 4'd4, 1'b0, 1'b0, ST_OK},
    '{31'd3, 32'd0, 31'd3, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd6, 32'd1, 31'd4, 4'd1, 1'b0, 1'b0, ST_OK},
    '{31'd2, 32'd1, 31'd2, 4'd2, 1'b1, 1'b0, ST_OK}
  };

  logic [31:0] burst_plan [] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd64, 32'd0, 32'd16};

  initial begin
    int unsigned items;
    burst_bytes = BURST_RESET;
    clear_layout();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset burst size.
    foreach (directed[i]) load_dimension(directed[i]);

    // Random tensors across several burst settings, extremes included.
    foreach (burst_plan[p]) begin
      write_burst((p == burst_plan.size() - 2) ? $urandom_range(1, 300) : burst_plan[p]);
      items = 0;
      no_gaps = (p % 3 == 1);
      while (items < ((burst_plan[p] == 0 && p == 0) ? 10 : 55)) random_tensor(items);
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && descriptor_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
